// ----- src/matrix4x4_multiply_unit_assert.svh -----
// Assertion macros for the matrix multiply unit
`ifndef MATRIX4X4_MULTIPLY_UNIT_ASSERT_SVH
`define MATRIX4X4_MULTIPLY_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define MMU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define MMU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mmu_pkg.sv -----
// Shared types and constants for the matrix multiply unit
`default_nettype none
package mmu_pkg;

  localparam int FIELD_W = 32;
  localparam int INDEX_W = 2;
  localparam int SHIFT_W = 5;
  localparam logic [SHIFT_W-1:0] FRACTION_SHIFT_RESET = 5'd16;

  typedef struct packed {
    logic wr_a_en;
    logic wr_b_en;
    logic advance;
  } lane_ctrl_t;

  typedef struct packed {
    logic               last;
    logic [INDEX_W-1:0] col;
    logic [INDEX_W-1:0] row;
  } side_t;

endpackage
`default_nettype wire

// ----- src/mmu_lane.sv -----
// One dot-product lane: column k of A, row k of B, registered read and multiply
`default_nettype none
module mmu_lane
  import mmu_pkg::*;
#(
  parameter int DIMENSION  = 4,
  parameter int DATA_WIDTH = 32
) (
  input  wire                                clk,
  input  wire  lane_ctrl_t                   ctrl,
  input  wire  [$clog2(DIMENSION)-1:0]       wr_a_addr,
  input  wire  [$clog2(DIMENSION)-1:0]       wr_b_addr,
  input  wire  [DATA_WIDTH-1:0]              wr_a_data,
  input  wire  [DATA_WIDTH-1:0]              wr_b_data,
  input  wire  [$clog2(DIMENSION)-1:0]       rd_a_addr,
  input  wire  [$clog2(DIMENSION)-1:0]       rd_b_addr,
  output logic signed [2*DATA_WIDTH-1:0]     product_r
);

  logic [DATA_WIDTH-1:0]        mem_a [DIMENSION];
  logic [DATA_WIDTH-1:0]        mem_b [DIMENSION];
  logic signed [DATA_WIDTH-1:0] rd_a_r;
  logic signed [DATA_WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (ctrl.wr_a_en) begin
      mem_a[wr_a_addr] <= wr_a_data;
    end
    if (ctrl.wr_b_en) begin
      mem_b[wr_b_addr] <= wr_b_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      rd_a_r    <= mem_a[rd_a_addr];
      rd_b_r    <= mem_b[rd_b_addr];
      product_r <= rd_a_r * rd_b_r;
    end
  end

endmodule
`default_nettype wire

// ----- src/mmu_merge.sv -----
// Merge stage: sum lane products, shift, saturate, hold the result item
`default_nettype none
module mmu_merge
  import mmu_pkg::*;
#(
  parameter int DIMENSION  = 4,
  parameter int DATA_WIDTH = 32
) (
  input  wire                                       clk,
  input  wire                                       rst_n,
  input  wire                                       advance,
  input  wire                                       in_valid,
  input  wire  side_t                               in_side,
  input  wire  [DIMENSION-1:0][2*DATA_WIDTH-1:0]    products,
  input  wire  [SHIFT_W-1:0]                        fraction_shift,
  output logic                                      out_valid_r,
  output logic [FIELD_W-1:0]                        out_data_r,
  output side_t                                     out_side_r
);

  localparam int P_W   = 2 * DATA_WIDTH;
  localparam int SUM_W = P_W + $clog2(DIMENSION) + 1;
  localparam int HALF  = (DIMENSION + 1) / 2;
  localparam logic signed [SUM_W-1:0] SAT_MAX =
    {{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

  logic signed [SUM_W-1:0]      lo_sum;
  logic signed [SUM_W-1:0]      hi_sum;
  logic signed [SUM_W-1:0]      lo_r;
  logic signed [SUM_W-1:0]      hi_r;
  logic signed [SUM_W-1:0]      total_r;
  logic signed [SUM_W-1:0]      shifted_r;
  logic signed [DATA_WIDTH-1:0] sat_val;
  logic                         v3_r;
  logic                         v4_r;
  logic                         v5_r;
  side_t                        side3_r;
  side_t                        side4_r;
  side_t                        side5_r;

  always_comb begin
    lo_sum = '0;
    hi_sum = '0;
    for (int k = 0; k < HALF; k++) begin
      lo_sum = lo_sum + SUM_W'($signed(products[k]));
    end
    for (int k = HALF; k < DIMENSION; k++) begin
      hi_sum = hi_sum + SUM_W'($signed(products[k]));
    end
  end

  always_comb begin
    priority if (shifted_r > SAT_MAX) begin
      sat_val = SAT_MAX[DATA_WIDTH-1:0];
    end else if (shifted_r < SAT_MIN) begin
      sat_val = SAT_MIN[DATA_WIDTH-1:0];
    end else begin
      sat_val = shifted_r[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v3_r        <= in_valid;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lo_r       <= lo_sum;
      hi_r       <= hi_sum;
      side3_r    <= in_side;
      total_r    <= lo_r + hi_r;
      side4_r    <= side3_r;
      shifted_r  <= total_r >>> fraction_shift;
      side5_r    <= side4_r;
      out_data_r <= FIELD_W'(sat_val);
      out_side_r <= side5_r;
    end
  end

endmodule
`default_nettype wire

// ----- src/matrix4x4_multiply_unit.sv -----
// Matrix multiply unit top level: load sequencer, dot-product lanes, merge
//
// Input stream: each item carries one element of A (in_tdata[31:0]) and the
// element of B at the same position (in_tdata[63:32]), row-major order.
// After DIMENSION*DIMENSION items the block stops taking input and computes
// C = A x B, one entry per unstalled cycle, DIMENSION multiplier lanes
// in parallel, then a summing, shifting and saturating merge.
// Output stream: one item per entry of C, row-major; out_tdata is the
// saturated entry, out_tuser gives row and column, out_tlast marks the end.
// The first entry passes the lane read and product registers, then the
// merge's partial-sum, total, shift and output registers; the rest follow
// one per cycle while the receiver does not stall. Loading resumes as soon
// as the last entry is issued into the lanes; loading waits while the
// single set of stores is read out. Reset clears the load position, the
// pipeline valids and restores fraction_shift to 16; stored elements are
// not cleared. A stalled receiver freezes the whole compute pipeline and
// the issue counter; nothing is dropped. The user must write cfg_wr_data
// only while idle; the block itself does not enforce it.
`default_nettype none
module matrix4x4_multiply_unit
  import mmu_pkg::*;
#(
  parameter int DIMENSION  = 4,
  parameter int DATA_WIDTH = 32
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  wire  [2*FIELD_W-1:0]   in_tdata,   // a_element, b_element
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [FIELD_W-1:0]     out_tdata,  // product_element
  output logic [2*INDEX_W-1:0]   out_tuser,  // row_index, column_index
  output logic                   out_tlast,  // last_entry
  input  wire                    cfg_wr_en,
  input  wire  [SHIFT_W-1:0]     cfg_wr_data // fraction_shift
);

  localparam int IDX_W = $clog2(DIMENSION);
  localparam int P_W   = 2 * DATA_WIDTH;
  localparam logic [IDX_W-1:0]   IDX_END  = IDX_W'(DIMENSION - 1);
  localparam logic [IDX_W+1:0]   LAST_EXT = (IDX_W+2)'(DIMENSION - 1);
  localparam logic [2*INDEX_W-1:0] LAST_USER = {LAST_EXT[1:0], LAST_EXT[1:0]};
  localparam logic PH_LOAD    = 1'b0;
  localparam logic PH_COMPUTE = 1'b1;

  logic                       phase_r;
  logic                       phase_nxt;
  logic [IDX_W-1:0]           cnt_row_r;
  logic [IDX_W-1:0]           cnt_row_nxt;
  logic [IDX_W-1:0]           cnt_col_r;
  logic [IDX_W-1:0]           cnt_col_nxt;
  logic [SHIFT_W-1:0]         shift_r;
  logic                       in_accept;
  logic                       advance;
  logic                       issue;
  logic                       step;
  logic                       row_end;
  logic                       col_end;
  logic [IDX_W+1:0]           row_ext;
  logic [IDX_W+1:0]           col_ext;
  side_t                      side_issue;
  side_t                      side1_r;
  side_t                      side2_r;
  side_t                      out_side;
  logic                       v1_r;
  logic                       v2_r;
  logic [DIMENSION-1:0][P_W-1:0] products;

  assign in_tready = (phase_r == PH_LOAD);
  assign in_accept = in_tvalid & in_tready;
  assign advance   = ~out_tvalid | out_tready;
  assign issue     = (phase_r == PH_COMPUTE) & advance;
  assign row_end   = (cnt_row_r == IDX_END);
  assign col_end   = (cnt_col_r == IDX_END);
  assign row_ext   = (IDX_W+2)'(cnt_row_r);
  assign col_ext   = (IDX_W+2)'(cnt_col_r);

  always_comb begin
    side_issue.last = row_end & col_end;
    side_issue.row  = row_ext[1:0];
    side_issue.col  = col_ext[1:0];
  end

  always_comb begin
    phase_nxt   = phase_r;
    cnt_row_nxt = cnt_row_r;
    cnt_col_nxt = cnt_col_r;
    step        = 1'b0;
    unique case (phase_r)
      PH_LOAD:    step = in_accept;
      PH_COMPUTE: step = advance;
    endcase
    if (step) begin
      if (col_end) begin
        cnt_col_nxt = '0;
        if (row_end) begin
          cnt_row_nxt = '0;
          phase_nxt   = (phase_r == PH_LOAD) ? PH_COMPUTE : PH_LOAD;
        end else begin
          cnt_row_nxt = cnt_row_r + 1'b1;
        end
      end else begin
        cnt_col_nxt = cnt_col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LOAD;
      cnt_row_r <= '0;
      cnt_col_r <= '0;
      shift_r   <= FRACTION_SHIFT_RESET;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      cnt_row_r <= cnt_row_nxt;
      cnt_col_r <= cnt_col_nxt;
      if (cfg_wr_en) begin
        shift_r <= cfg_wr_data;
      end
      if (advance) begin
        v1_r <= issue;
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      side1_r <= side_issue;
      side2_r <= side1_r;
    end
  end

  for (genvar k = 0; k < DIMENSION; k++) begin : g_lane
    lane_ctrl_t ctrl;

    always_comb begin
      ctrl.wr_a_en = in_accept & (cnt_col_r == IDX_W'(k));
      ctrl.wr_b_en = in_accept & (cnt_row_r == IDX_W'(k));
      ctrl.advance = advance;
    end

    mmu_lane #(
      .DIMENSION  (DIMENSION),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_lane (
      .clk       (clk),
      .ctrl      (ctrl),
      .wr_a_addr (cnt_row_r),
      .wr_b_addr (cnt_col_r),
      .wr_a_data (in_tdata[DATA_WIDTH-1:0]),
      .wr_b_data (in_tdata[FIELD_W+DATA_WIDTH-1:FIELD_W]),
      .rd_a_addr (cnt_row_r),
      .rd_b_addr (cnt_col_r),
      .product_r (products[k])
    );
  end

  mmu_merge #(
    .DIMENSION  (DIMENSION),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .in_valid       (v2_r),
    .in_side        (side2_r),
    .products       (products),
    .fraction_shift (shift_r),
    .out_valid_r    (out_tvalid),
    .out_data_r     (out_tdata),
    .out_side_r     (out_side)
  );

  assign out_tuser = {out_side.col, out_side.row};
  assign out_tlast = out_side.last;

`include "matrix4x4_multiply_unit_assert.svh"

  `MMU_ASSERT_NOW(a_last_at_corner, out_tvalid && out_tlast, out_tuser == LAST_USER,
    "last entry not at final row and column")
  `MMU_ASSERT_NEXT(a_load_done_blocks, in_accept && row_end && col_end, !in_tready,
    "input still accepted after a full matrix pair")
  `MMU_ASSERT_NEXT(a_stall_holds_issue, (phase_r == PH_COMPUTE) && !advance,
    $stable(cnt_row_r) && $stable(cnt_col_r), "issue position moved during stall")

endmodule
`default_nettype wire
